FILE: rtl/chr_pkg.sv
// Package: shared constants, codes and types of the consistent-hash ring lookup.
package chr_pkg;

  localparam int unsigned MAX_POINTS    = 256;
  localparam int unsigned ENTRY_ID_BITS = 8;
  localparam int unsigned HASH_W        = 32;
  localparam int unsigned ACTION_W      = 2;
  localparam int unsigned STATUS_W      = 2;
  localparam int unsigned IDX_W         = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int unsigned CNT_W         = $clog2(MAX_POINTS + 1);

  typedef enum logic [ACTION_W-1:0] {
    ACT_LOAD   = 2'd0,
    ACT_LOOKUP = 2'd1,
    ACT_CLEAR  = 2'd2
  } action_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    logic [HASH_W-1:0]        hash;
    logic [ENTRY_ID_BITS-1:0] entry;
  } point_t;

endpackage

FILE: rtl/chr_in_if.sv
// Interface: input item channel (action, hash and entry id).
interface chr_in_if;
  logic                             valid;
  logic                             ready;
  logic [chr_pkg::ACTION_W-1:0]      action;
  logic [chr_pkg::HASH_W-1:0]        ring_hash;
  logic [chr_pkg::ENTRY_ID_BITS-1:0] entry_id;

  modport source (output valid, output action, output ring_hash, output entry_id,
                  input ready);
  modport sink   (input valid, input action, input ring_hash, input entry_id,
                  output ready);
endinterface

FILE: rtl/chr_out_if.sv
// Interface: result channel (chosen entry id and status).
interface chr_out_if;
  logic                             valid;
  logic                             ready;
  logic [chr_pkg::ENTRY_ID_BITS-1:0] entry_id_out;
  logic [chr_pkg::STATUS_W-1:0]      status;

  modport source (output valid, output entry_id_out, output status, input ready);
  modport sink   (input valid, input entry_id_out, input status, output ready);
endinterface

FILE: rtl/consistent_hash_ring_lookup.sv
// Top level: consistent-hash ring with sorted point memory, insert and lookup.
//
// Usage: items arrive on in_i (valid/ready). Action load inserts a point
// (ring_hash, entry_id) into the table sorted by hash, after equal hashes;
// lookup returns the entry of the first point with hash >= key, wrapping to
// the lowest point; clear empties the table. Each item yields exactly one
// transfer on out_o (entry_id_out, status).
// Clear, reserved code, lookup on an empty table and load into an empty or full
// table go straight from idle to the done state; a lookup takes at most
// ceil(log2(count+1)) binary search steps, each paced by the registered memory
// read, and one wrap read more when it wraps; a load into a nonempty table
// moves each point above it up one slot, one memory move per cycle.
// One item is in work at a time; in_i.ready is high whenever no item is in work,
// even while a result waits.
// Reset empties the table (point count zero); memory contents are not cleared
// and are never read before they are written.
// A stalled receiver holds the result in the output register; the next item then
// waits with its result in the done state, taking no further item until the transfer.
module consistent_hash_ring_lookup (
  input  logic       clk_i,
  input  logic       rst_ni,
  chr_in_if.sink     in_i,
  chr_out_if.source  out_o
);
  import chr_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SRCH  = 6'b000010,
    S_WRAP  = 6'b000100,
    S_SHIFT = 6'b001000,
    S_INS   = 6'b010000,
    S_DONE  = 6'b100000
  } state_e;

  state_e                   state_q, state_d;
  logic [CNT_W-1:0]         cnt_q, cnt_d;
  logic [CNT_W-1:0]         lo_q, lo_d, hi_q, hi_d, mid_q, mid_d;
  logic [IDX_W-1:0]         j_q, j_d;
  logic [HASH_W-1:0]        key_q, key_d;
  logic [ENTRY_ID_BITS-1:0] ent_q, ent_d;
  logic [ENTRY_ID_BITS-1:0] cand_q, cand_d;
  logic                     found_q, found_d;
  logic [ENTRY_ID_BITS-1:0] res_id_q, res_id_d;
  status_e                  res_st_q, res_st_d;
  logic                     out_vld_q, out_vld_d;
  logic [ENTRY_ID_BITS-1:0] out_id_q, out_id_d;
  logic [STATUS_W-1:0]      out_st_q, out_st_d;

  // Point memory: one write and one registered read port
  point_t                   mem [MAX_POINTS];
  point_t                   rd_q;
  logic                     re, we;
  logic [IDX_W-1:0]         ra, wa;
  point_t                   wd;

  logic                     in_acc;
  logic                     out_free;
  logic                     go_right;
  logic [CNT_W-1:0]         lo_n, hi_n, span_n;
  logic [CNT_W-1:0]         mid_init;

  assign in_acc   = in_i.valid && in_i.ready;
  assign out_free = !out_vld_q || out_o.ready;
  assign in_i.ready = (state_q == S_IDLE);

  assign out_o.valid        = out_vld_q;
  assign out_o.entry_id_out = out_id_q;
  assign out_o.status       = out_st_q;

  // Search step: next bounds from the compare on the point just read
  assign go_right = (rd_q.hash < key_q);
  assign lo_n     = go_right ? (mid_q + CNT_W'(1)) : lo_q;
  assign hi_n     = go_right ? hi_q : mid_q;
  assign span_n   = hi_n - lo_n;
  assign mid_init = cnt_q >> 1;

  // Sequencer: search, wrap read, tail shift and insert
  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    lo_d      = lo_q;
    hi_d      = hi_q;
    mid_d     = mid_q;
    j_d       = j_q;
    key_d     = key_q;
    ent_d     = ent_q;
    cand_d    = cand_q;
    found_d   = found_q;
    res_id_d  = res_id_q;
    res_st_d  = res_st_q;
    out_vld_d = out_vld_q;
    out_id_d  = out_id_q;
    out_st_d  = out_st_q;
    re        = 1'b0;
    ra        = '0;
    we        = 1'b0;
    wa        = '0;
    wd        = '{hash: key_q, entry: ent_q};

    // Drop the result once the receiver takes it
    if (out_vld_q && out_o.ready) begin
      out_vld_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          key_d    = in_i.ring_hash;
          ent_d    = in_i.entry_id;
          res_id_d = '0;
          res_st_d = ST_OK;
          found_d  = 1'b0;
          state_d  = S_DONE;
          case (in_i.action)
            ACT_LOAD: begin
              if (cnt_q >= CNT_W'(MAX_POINTS)) begin
                res_st_d = ST_FULL;
              end else begin
                cnt_d = cnt_q + CNT_W'(1);
                if (cnt_q == '0) begin
                  we = 1'b1;
                  wa = '0;
                  wd = '{hash: in_i.ring_hash, entry: in_i.entry_id};
                end else begin
                  re      = 1'b1;
                  ra      = IDX_W'(cnt_q - CNT_W'(1));
                  j_d     = IDX_W'(cnt_q - CNT_W'(1));
                  state_d = S_SHIFT;
                end
              end
            end
            ACT_LOOKUP: begin
              if (cnt_q == '0) begin
                res_st_d = ST_EMPTY;
              end else begin
                lo_d    = '0;
                hi_d    = cnt_q;
                mid_d   = mid_init;
                re      = 1'b1;
                ra      = IDX_W'(mid_init);
                state_d = S_SRCH;
              end
            end
            ACT_CLEAR: begin
              cnt_d = '0;
            end
            default: begin
            end
          endcase
        end
      end

      S_SRCH: begin
        lo_d = lo_n;
        hi_d = hi_n;
        if (!go_right) begin
          cand_d  = rd_q.entry;
          found_d = 1'b1;
        end
        if (lo_n < hi_n) begin
          mid_d = lo_n + (span_n >> 1);
          re    = 1'b1;
          ra    = IDX_W'(lo_n + (span_n >> 1));
        end else if (!go_right) begin
          res_id_d = rd_q.entry;
          state_d  = S_DONE;
        end else if (found_q) begin
          res_id_d = cand_q;
          state_d  = S_DONE;
        end else begin
          // Key above every point: wrap to the lowest one
          re      = 1'b1;
          ra      = '0;
          state_d = S_WRAP;
        end
      end

      S_WRAP: begin
        res_id_d = rd_q.entry;
        state_d  = S_DONE;
      end

      S_SHIFT: begin
        we = 1'b1;
        wa = j_q + IDX_W'(1);
        if (rd_q.hash > key_q) begin
          // Move the point up one slot and continue downward
          wd = rd_q;
          if (j_q == '0) begin
            state_d = S_INS;
          end else begin
            re  = 1'b1;
            ra  = j_q - IDX_W'(1);
            j_d = j_q - IDX_W'(1);
          end
        end else begin
          state_d = S_DONE;
        end
      end

      S_INS: begin
        we      = 1'b1;
        wa      = '0;
        state_d = S_DONE;
      end

      S_DONE: begin
        if (out_free) begin
          out_vld_d = 1'b1;
          out_id_d  = res_id_q;
          out_st_d  = res_st_q;
          state_d   = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Hold the point memory; reads and writes never hit the same slot together
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      rd_q <= mem[ra];
    end
  end

  // Advance control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= '0;
      out_vld_q <= 1'b0;
      found_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      out_vld_q <= out_vld_d;
      found_q   <= found_d;
    end
  end

  // Hold working and result payload
  always_ff @(posedge clk_i) begin
    lo_q     <= lo_d;
    hi_q     <= hi_d;
    mid_q    <= mid_d;
    j_q      <= j_d;
    key_q    <= key_d;
    ent_q    <= ent_d;
    cand_q   <= cand_d;
    res_id_q <= res_id_d;
    res_st_q <= res_st_d;
    out_id_q <= out_id_d;
    out_st_q <= out_st_d;
  end

  // Point count never passes the table size
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(MAX_POINTS))
    else $error("point count above table size");

  // Search window stays nonempty and inside the table
  a_srch_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SRCH) |-> (lo_q < hi_q) && (hi_q <= cnt_q) && (mid_q < hi_q))
    else $error("search window out of range");

  // Memory writes only during a load
  a_write_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we |-> (state_q == S_SHIFT) || (state_q == S_INS) || (state_q == S_IDLE && in_acc))
    else $error("memory write outside a load");

  // A new result appears only from the done state
  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !$past(out_vld_q && !out_o.ready)) |-> $past(state_q == S_DONE))
    else $error("result issued outside done state");

endmodule

FILE: dv/consistent_hash_ring_lookup_test.sv
// Testbench: directed and random load, lookup and clear traffic against a ring predictor.
`timescale 1ns / 100ps

module consistent_hash_ring_lookup_test;
  import chr_pkg::*;

  localparam logic [ACTION_W-1:0] ACT_RESERVED = 2'd3;
  localparam int unsigned         N_DIRECTED   = 20;
  localparam int unsigned         SETTLE_CYCLES = 300;

  typedef struct packed {
    logic [ENTRY_ID_BITS-1:0] entry;
    status_e                  status;
  } ring_result_t;

  typedef struct {
    logic [ACTION_W-1:0]      action;
    logic [HASH_W-1:0]        hash;
    logic [ENTRY_ID_BITS-1:0] entry;
    bit                       known;
    logic [ENTRY_ID_BITS-1:0] exp_entry;
    status_e                  exp_status;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  chr_in_if  in_if ();
  chr_out_if out_if ();

  consistent_hash_ring_lookup dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if.sink),
    .out_o  (out_if.source)
  );

  // Ring copy, kept sorted by hash with equal hashes in load order
  point_t       ring_pts[$];
  ring_result_t ring_expect_q[$];
  int unsigned  err_cnt = 0;
  int unsigned  send_idle_pct = 0;
  int unsigned  recv_stall_pct = 0;
  dir_row_t     dir_rows[N_DIRECTED];

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Apply one item to the ring copy and return the result it must produce
  function automatic ring_result_t ring_predict(input logic [ACTION_W-1:0] act,
                                                input logic [HASH_W-1:0] hv,
                                                input logic [ENTRY_ID_BITS-1:0] eid);
    ring_result_t res;
    point_t       p;
    int           pos;
    res.entry  = '0;
    res.status = ST_OK;
    if (act == ACT_LOAD) begin
      if (ring_pts.size() >= MAX_POINTS) begin
        res.status = ST_FULL;
      end else begin
        pos = ring_pts.size();
        for (int i = 0; i < ring_pts.size(); i++) begin
          if (ring_pts[i].hash > hv) begin
            pos = i;
            break;
          end
        end
        p.hash  = hv;
        p.entry = eid;
        ring_pts.insert(pos, p);
      end
    end else if (act == ACT_LOOKUP) begin
      if (ring_pts.size() == 0) begin
        res.status = ST_EMPTY;
      end else begin
        pos = 0;
        for (int i = 0; i < ring_pts.size(); i++) begin
          if (ring_pts[i].hash >= hv) begin
            pos = i;
            break;
          end
        end
        res.entry = ring_pts[pos].entry;
      end
    end else if (act == ACT_CLEAR) begin
      ring_pts.delete();
    end
    return res;
  endfunction

  // Point hash: wide random, narrow range for duplicates, or an extreme
  function automatic logic [HASH_W-1:0] pick_point_hash();
    logic [HASH_W-1:0] h;
    case ($urandom_range(3))
      0: h = $urandom_range(15);
      1: begin
        case ($urandom_range(4))
          0: h = '0;
          1: h = 32'd1;
          2: h = 32'h8000_0000;
          3: h = 32'hFFFF_FFFE;
          default: h = '1;
        endcase
      end
      default: h = $urandom;
    endcase
    return h;
  endfunction

  // Lookup key: near a stored point, an extreme, or random
  function automatic logic [HASH_W-1:0] pick_key();
    logic [HASH_W-1:0] k;
    int                sel;
    sel = $urandom_range(5);
    if (ring_pts.size() != 0 && sel < 3) begin
      k = ring_pts[$urandom_range(ring_pts.size() - 1)].hash;
      if (sel == 1) k = k + 1;
      if (sel == 2) k = k - 1;
    end else if (sel == 3) begin
      k = '0;
    end else if (sel == 4) begin
      k = '1;
    end else begin
      k = $urandom;
    end
    return k;
  endfunction

  // Present one item, hold it until the transfer, then record its expectation
  task automatic drive_item(input logic [ACTION_W-1:0] act,
                            input logic [HASH_W-1:0] hv,
                            input logic [ENTRY_ID_BITS-1:0] eid,
                            input bit known = 1'b0,
                            input logic [ENTRY_ID_BITS-1:0] exp_entry = '0,
                            input status_e exp_status = ST_OK);
    ring_result_t res;
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid     <= 1'b1;
    in_if.action    <= act;
    in_if.ring_hash <= hv;
    in_if.entry_id  <= eid;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    res = ring_predict(act, hv, eid);
    if (known) begin
      res.entry  = exp_entry;
      res.status = exp_status;
    end
    ring_expect_q.push_back(res);
  endtask

  // Hold the sender until every expected result has arrived
  task automatic wait_drained();
    @(negedge clk_i);
    in_if.valid <= 1'b0;
    while (ring_expect_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic load_points(input int n, inout int sent);
    for (int i = 0; i < n; i++) begin
      drive_item(ACT_LOAD, pick_point_hash(), $urandom_range(255));
      sent++;
    end
  endtask

  task automatic lookup_keys(input int n, inout int sent);
    for (int i = 0; i < n; i++) begin
      drive_item(ACT_LOOKUP, pick_key(), $urandom_range(255));
      sent++;
    end
  endtask

  // One traffic phase: mostly clear/load/lookup sequences, some noise
  task automatic run_phase(input int quota, input int idle_pct, input int stall_pct,
                           input bit fill_ring);
    int sent;
    int sel;
    sent           = 0;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    if (fill_ring) begin
      drive_item(ACT_CLEAR, $urandom, $urandom_range(255));
      sent++;
      load_points(MAX_POINTS, sent);
      wait_drained();
      load_points(3, sent);
      lookup_keys(30, sent);
    end
    while (sent < quota) begin
      sel = $urandom_range(99);
      if (sel < 80) begin
        if (sel < 65 || ring_pts.size() > 200) begin
          drive_item(ACT_CLEAR, $urandom, $urandom_range(255));
          sent++;
          if (sel < 5) lookup_keys(1, sent);
        end
        load_points($urandom_range(1, 12), sent);
        lookup_keys($urandom_range(1, 10), sent);
      end else begin
        sel = $urandom_range(3);
        // reserved code still yields one result
        drive_item(sel[ACTION_W-1:0], $urandom, $urandom_range(255));
        sent++;
      end
    end
    wait_drained();
  endtask

  // Receiver backpressure
  always @(negedge clk_i) begin
    out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Compare each result transfer with the oldest expectation
  always @(posedge clk_i) begin
    ring_result_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (ring_expect_q.size() == 0) begin
        $error("unexpected result: entry_id_out %0d status %0d",
               out_if.entry_id_out, out_if.status);
        err_cnt++;
      end else begin
        want = ring_expect_q.pop_front();
        if (out_if.entry_id_out !== want.entry) begin
          $error("entry_id_out: expected %0d, actual %0d", want.entry, out_if.entry_id_out);
          err_cnt++;
        end
        if (out_if.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, out_if.status);
          err_cnt++;
        end
      end
    end
  end

  // Run time limit
  initial begin
    #10_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    in_if.valid     = 1'b0;
    in_if.action    = ACT_LOAD;
    in_if.ring_hash = '0;
    in_if.entry_id  = '0;
    out_if.ready    = 1'b0;
    rst_ni          = 1'b0;

    // action, hash, entry, known, expected entry, expected status
    dir_rows = '{
      '{ACT_LOOKUP,   32'h0000_0000, 8'h00, 1'b1, 8'h00, ST_EMPTY},
      '{ACT_LOAD,     32'h0000_0000, 8'hFF, 1'b1, 8'h00, ST_OK},
      '{ACT_LOAD,     32'hFFFF_FFFF, 8'h00, 1'b1, 8'h00, ST_OK},
      '{ACT_LOAD,     32'h0000_0000, 8'h5A, 1'b1, 8'h00, ST_OK},
      '{ACT_LOAD,     32'h8000_0000, 8'hA5, 1'b1, 8'h00, ST_OK},
      '{ACT_LOOKUP,   32'h0000_0000, 8'h00, 1'b1, 8'hFF, ST_OK},
      '{ACT_LOOKUP,   32'hFFFF_FFFF, 8'hFF, 1'b1, 8'h00, ST_OK},
      '{ACT_LOOKUP,   32'h0000_0001, 8'h00, 1'b0, 8'h00, ST_OK},
      '{ACT_LOOKUP,   32'h8000_0000, 8'h00, 1'b0, 8'h00, ST_OK},
      '{ACT_RESERVED, 32'hFFFF_FFFF, 8'hFF, 1'b1, 8'h00, ST_OK},
      '{ACT_CLEAR,    32'hFFFF_FFFF, 8'hFF, 1'b1, 8'h00, ST_OK},
      '{ACT_LOOKUP,   32'h8000_0000, 8'h00, 1'b1, 8'h00, ST_EMPTY},
      '{ACT_LOAD,     32'h0000_1000, 8'h11, 1'b1, 8'h00, ST_OK},
      '{ACT_LOAD,     32'h0000_2000, 8'h22, 1'b1, 8'h00, ST_OK},
      '{ACT_LOOKUP,   32'h0000_2001, 8'h00, 1'b0, 8'h00, ST_OK},
      '{ACT_LOOKUP,   32'hFFFF_FFFF, 8'h00, 1'b0, 8'h00, ST_OK},
      '{ACT_LOOKUP,   32'h0000_0000, 8'h00, 1'b0, 8'h00, ST_OK},
      '{ACT_LOAD,     32'h0000_2000, 8'h33, 1'b1, 8'h00, ST_OK},
      '{ACT_LOOKUP,   32'h0000_1FFF, 8'h00, 1'b0, 8'h00, ST_OK},
      '{ACT_CLEAR,    32'h0000_0000, 8'h00, 1'b1, 8'h00, ST_OK}
    };

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed table, no idling
    foreach (dir_rows[i]) begin
      drive_item(dir_rows[i].action, dir_rows[i].hash, dir_rows[i].entry,
                 dir_rows[i].known, dir_rows[i].exp_entry, dir_rows[i].exp_status);
    end
    wait_drained();

    // Random phases: free flow, sender gaps, receiver stalls, both
    run_phase(420, 0, 0, 1'b1);
    run_phase(400, 67, 0, 1'b0);
    run_phase(400, 0, 67, 1'b0);
    run_phase(430, 34, 34, 1'b1);

    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (ring_expect_q.size() != 0) begin
      $error("results still pending: %0d", ring_expect_q.size());
      err_cnt++;
    end
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
